@@ rtl/assert_macros.svh @@
// assertion macros for the rtl files, used by line_rasterizer.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk, off while rst is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked at every rising edge of clk, off while rst is high
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while rst is high
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lr_pkg.sv @@
// types and constants of the line rasterizer
`timescale 1ns / 1ps

package lr_pkg;

  localparam int COORD_W    = 6;
  localparam int COLOR_W    = 32;
  localparam int TWICE_W    = COORD_W + 1;
  localparam int ERR_W      = COORD_W + 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CQ_DEPTH   = 2;
  localparam int CQ_PTR_W   = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W   = CQ_PTR_W + 1;

  localparam logic [7:0] OPAQUE_ALPHA = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] pen_color;
  } lr_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last;
    logic               error;
  } lr_rsp_t;

  // classified line request, ready for the stepping loop
  typedef struct packed {
    logic                    is_error;
    logic [COORD_W-1:0]      start_x;
    logic [COORD_W-1:0]      start_y;
    logic [COORD_W-1:0]      goal_x;
    logic [COORD_W-1:0]      goal_y;
    logic [TWICE_W-1:0]      twice_dx;
    logic [TWICE_W-1:0]      twice_dy;
    logic                    step_neg_x;
    logic                    step_neg_y;
    logic                    x_major;
    logic signed [ERR_W-1:0] err_init;
    logic [COLOR_W-1:0]      color;
  } lr_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lr_cq_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAW
  } lr_state_t;

endpackage

@@ rtl/lr_front.sv @@
// front end: origin registers, endpoint offset and line setup
`timescale 1ns / 1ps

module lr_front import lr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  lr_req_t              req,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  input  lr_cq_stat_t          cq_stat,
  output logic                 cq_push,
  output lr_cmd_t              cq_cmd
);

  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [COORD_W-1:0] sx, sy, gx, gy;
  logic [COORD_W:0]   diff_x, diff_y, mag_x, mag_y;
  logic [COORD_W-1:0] abs_x, abs_y;
  logic               neg_x, neg_y, x_major;
  logic [TWICE_W-1:0] tdx, tdy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // sums wrap within the tile
    sx = req.start_x + origin_x;
    sy = req.start_y + origin_y;
    gx = req.end_x + origin_x;
    gy = req.end_y + origin_y;

    diff_x = {1'b0, gx} - {1'b0, sx};
    diff_y = {1'b0, gy} - {1'b0, sy};
    neg_x  = diff_x[COORD_W];
    neg_y  = diff_y[COORD_W];
    mag_x  = neg_x ? (~diff_x + 1'b1) : diff_x;
    mag_y  = neg_y ? (~diff_y + 1'b1) : diff_y;
    abs_x  = mag_x[COORD_W-1:0];
    abs_y  = mag_y[COORD_W-1:0];
    tdx    = {abs_x, 1'b0};
    tdy    = {abs_y, 1'b0};
    // a tie goes to y
    x_major = abs_x > abs_y;

    cq_cmd.is_error   = req.pen_color[COLOR_W-1 -: 8] != OPAQUE_ALPHA;
    cq_cmd.start_x    = sx;
    cq_cmd.start_y    = sy;
    cq_cmd.goal_x     = gx;
    cq_cmd.goal_y     = gy;
    cq_cmd.twice_dx   = tdx;
    cq_cmd.twice_dy   = tdy;
    cq_cmd.step_neg_x = neg_x;
    cq_cmd.step_neg_y = neg_y;
    cq_cmd.x_major    = x_major;
    cq_cmd.color      = req.pen_color;
    if (x_major) begin
      cq_cmd.err_init = $signed({2'b00, tdy} - {3'b000, abs_x});
    end else begin
      cq_cmd.err_init = $signed({2'b00, tdx} - {3'b000, abs_y});
    end
  end

  assign full    = cq_stat.full;
  assign cq_push = push && !cq_stat.full;

endmodule

@@ rtl/lr_cmd_fifo.sv @@
// short command queue between front end and stepping engine
`timescale 1ns / 1ps

module lr_cmd_fifo import lr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  lr_cmd_t     wr_data,
  input  logic        rd_en,
  output lr_cmd_t     rd_data,
  output lr_cq_stat_t stat
);

  lr_cmd_t             mem [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CQ_CNT_W-1:0] count;
  logic                do_wr, do_rd;

  assign stat.full  = count == CQ_CNT_W'(CQ_DEPTH);
  assign stat.empty = count == '0;
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/lr_back.sv @@
// stepping engine: walks the line one pixel a cycle into the result register while it is empty or popped
`timescale 1ns / 1ps

module lr_back import lr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_avail,
  input  lr_cmd_t cmd,
  output logic    cmd_take,
  output logic    empty,
  input  logic    pop,
  output lr_rsp_t rsp
);

  lr_state_t               state, state_next;
  logic                    out_valid, out_valid_next;
  lr_rsp_t                 out_data, out_data_next;
  logic [COORD_W-1:0]      cur_x, cur_y, goal_x, goal_y;
  logic [COORD_W-1:0]      cur_x_next, cur_y_next, goal_x_next, goal_y_next;
  logic signed [ERR_W-1:0] err_term, err_term_next;
  logic [TWICE_W-1:0]      twice_dx, twice_dy, twice_dx_next, twice_dy_next;
  logic                    step_neg_x, step_neg_y, x_major;
  logic                    step_neg_x_next, step_neg_y_next, x_major_next;
  logic [COLOR_W-1:0]      color, color_next;
  logic                    adv, err_ge, is_last;
  logic [COORD_W-1:0]      sx, sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data   <= out_data_next;
    cur_x      <= cur_x_next;
    cur_y      <= cur_y_next;
    goal_x     <= goal_x_next;
    goal_y     <= goal_y_next;
    err_term   <= err_term_next;
    twice_dx   <= twice_dx_next;
    twice_dy   <= twice_dy_next;
    step_neg_x <= step_neg_x_next;
    step_neg_y <= step_neg_y_next;
    x_major    <= x_major_next;
    color      <= color_next;
  end

  always_comb begin
    adv             = !out_valid || pop;
    state_next      = state;
    out_valid_next  = out_valid && !pop;
    out_data_next   = out_data;
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    goal_x_next     = goal_x;
    goal_y_next     = goal_y;
    err_term_next   = err_term;
    twice_dx_next   = twice_dx;
    twice_dy_next   = twice_dy;
    step_neg_x_next = step_neg_x;
    step_neg_y_next = step_neg_y;
    x_major_next    = x_major;
    color_next      = color;
    cmd_take        = 1'b0;
    err_ge          = !err_term[ERR_W-1];
    is_last         = 1'b0;
    sx              = cur_x;
    sy              = cur_y;

    unique case (state)
      ST_IDLE: begin
        if (adv && cmd_avail) begin
          cmd_take       = 1'b1;
          out_valid_next = 1'b1;
          if (cmd.is_error) begin
            out_data_next.pixel_x     = '0;
            out_data_next.pixel_y     = '0;
            out_data_next.pixel_color = '0;
            out_data_next.last        = 1'b1;
            out_data_next.error       = 1'b1;
          end else begin
            cur_x_next      = cmd.start_x;
            cur_y_next      = cmd.start_y;
            goal_x_next     = cmd.goal_x;
            goal_y_next     = cmd.goal_y;
            err_term_next   = cmd.err_init;
            twice_dx_next   = cmd.twice_dx;
            twice_dy_next   = cmd.twice_dy;
            step_neg_x_next = cmd.step_neg_x;
            step_neg_y_next = cmd.step_neg_y;
            x_major_next    = cmd.x_major;
            color_next      = cmd.color;
            is_last = cmd.x_major ? (cmd.start_x == cmd.goal_x)
                                  : (cmd.start_y == cmd.goal_y);
            out_data_next.pixel_x     = cmd.start_x;
            out_data_next.pixel_y     = cmd.start_y;
            out_data_next.pixel_color = cmd.color;
            out_data_next.last        = is_last;
            out_data_next.error       = 1'b0;
            if (!is_last) begin
              state_next = ST_DRAW;
            end
          end
        end
      end
      ST_DRAW: begin
        if (adv) begin
          // minor axis steps when the error term is not negative
          if (x_major) begin
            sx = step_neg_x ? cur_x - 1'b1 : cur_x + 1'b1;
            if (err_ge) begin
              sy = step_neg_y ? cur_y - 1'b1 : cur_y + 1'b1;
            end
            err_term_next = err_term + $signed({2'b00, twice_dy})
                            - (err_ge ? $signed({2'b00, twice_dx}) : '0);
            is_last = sx == goal_x;
          end else begin
            sy = step_neg_y ? cur_y - 1'b1 : cur_y + 1'b1;
            if (err_ge) begin
              sx = step_neg_x ? cur_x - 1'b1 : cur_x + 1'b1;
            end
            err_term_next = err_term + $signed({2'b00, twice_dx})
                            - (err_ge ? $signed({2'b00, twice_dy}) : '0);
            is_last = sy == goal_y;
          end
          cur_x_next     = sx;
          cur_y_next     = sy;
          out_valid_next = 1'b1;
          out_data_next.pixel_x     = sx;
          out_data_next.pixel_y     = sy;
          out_data_next.pixel_color = color;
          out_data_next.last        = is_last;
          out_data_next.error       = 1'b0;
          if (is_last) begin
            state_next = ST_IDLE;
          end
        end
      end
    endcase
  end

  assign empty = !out_valid;
  assign rsp   = out_data;

endmodule

@@ rtl/line_rasterizer.sv @@
// top level of the line rasterizer
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Bresenham line rasterizer for a 64 by 64 pixel tile. A line request is
// taken whenever full is low; the front end adds the origin registers to
// both endpoints (wrapping within the tile), sets up the deltas and the
// error term in the same cycle, and parks the request in a two-entry command
// queue. The stepping engine pulls requests from that queue and produces one
// pixel per cycle, while its result register is empty or being popped, into
// that single result register, so a line gives |major-axis delta| + 1 pixels
// (1 to 64); a request with a pen alpha other than 255 gives one error beat.
// Up to two further requests are taken while a line is being drawn, and a
// stalled result holds only the stepping engine. Origin registers are written
// through cfg_valid/cfg_ready (always ready) at index 0 (x) and 1 (y).

module line_rasterizer import lr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  lr_req_t              req,
  output logic                 empty,
  input  logic                 pop,
  output lr_rsp_t              rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  lr_cq_stat_t cq_stat;
  logic        cq_push, cq_take;
  lr_cmd_t     cq_wr_cmd, cq_rd_cmd;

  lr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cq_stat   (cq_stat),
    .cq_push   (cq_push),
    .cq_cmd    (cq_wr_cmd)
  );

  lr_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cq_push),
    .wr_data (cq_wr_cmd),
    .rd_en   (cq_take),
    .rd_data (cq_rd_cmd),
    .stat    (cq_stat)
  );

  lr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (!cq_stat.empty),
    .cmd       (cq_rd_cmd),
    .cmd_take  (cq_take),
    .empty     (empty),
    .pop       (pop),
    .rsp       (rsp)
  );

  // the engine only takes a command that is there
  `ASSERT_IMPL(a_take_nonempty, cq_take, !cq_stat.empty, "command taken from empty queue")
  // an error beat always closes its request
  `ASSERT_IMPL(a_error_last, !empty && rsp.error, rsp.last && rsp.pixel_color == '0, "bad error beat")
  // drawn pixels always carry an opaque pen
  `ASSERT_IMPL(a_opaque_pixel, !empty && !rsp.error,
               rsp.pixel_color[COLOR_W-1 -: 8] == OPAQUE_ALPHA, "pixel with non-opaque pen")
  // a line in progress is never cut by an error beat
  `ASSERT_NEXT(a_line_continues, pop && !empty && !rsp.last, empty || !rsp.error,
               "error beat inside a line")

endmodule
